### hdl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check on rising clk with async reset disable
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// check that holds on every edge
`define CHK_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("check failed");
`endif

### hdl/mpsc_pkg.sv
// matching pursuit sparse coder package: opcodes, states, fixed-point helpers
// no dependencies
package mpsc_pkg;

  localparam int unsigned VAL_W = 24;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned ACC_W = 56;
  localparam int unsigned PROD_W = 40;

  typedef enum logic [1:0] {
    OP_LOAD_DICT = 2'd0,
    OP_LOAD_SIG  = 2'd1,
    OP_RUN       = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_SIG_LEN   = 2'd0,
    CFG_ATOM_CNT  = 2'd1,
    CFG_SPARSITY  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_DOT,
    ST_DOT_WAIT,
    ST_PICK,
    ST_PROJ,
    ST_UPD,
    ST_UPD_WAIT,
    ST_EMIT_COEF,
    ST_EMIT_RES,
    ST_RES_WAIT
  } state_e;

  // round to nearest, ties away from zero, shifted right by 15
  function automatic logic signed [ACC_W-1:0] round15(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] r;
    begin
      m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      r = (m + ACC_W'(16384)) >> 15;
      round15 = v[ACC_W-1] ? -$signed(r) : $signed(r);
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    begin
      if (v > ACC_W'(signed'(25'sd8388607))) sat24 = 24'sh7FFFFF;
      else if (v < -ACC_W'(signed'(25'sd8388608))) sat24 = 24'sh800000;
      else sat24 = v[VAL_W-1:0];
    end
  endfunction

endpackage

### hdl/matching_pursuit_sparse_coder_core.sv
// Greedy matching pursuit over a dictionary and a signal held on chip. Load
// beats (dictionary word or signal sample) are written into memory while the
// core is idle. A run beat copies the signal into the residual. Each round
// then uses one shared multiply-accumulate unit to walk every atom in use,
// skipping the dot product of an atom already chosen. It applies the
// projection to the residual and emits the coefficient. Finally the residual
// is emitted, one beat per sample. Run time is set by the single MAC and the
// one-read memories. A stalled output holds the sequencer at the beat it is
// emitting. No input beat is taken while a run is in progress.
`include "assert_macros.svh"
module matching_pursuit_sparse_coder_core #(
  parameter int unsigned MAX_SIGNAL_LEN = 16,
  parameter int unsigned MAX_ATOMS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  row_index_i,
  input  logic [4:0]  atom_index_i,
  input  logic signed [15:0] dict_word_i,
  input  logic signed [23:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [4:0]  index_o,
  output logic signed [23:0] value_o,
  output logic        last_o
);

  localparam int unsigned RW = (MAX_SIGNAL_LEN > 1) ? $clog2(MAX_SIGNAL_LEN) : 1;
  localparam int unsigned AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int unsigned DW = RW + AW;
  localparam int unsigned ACC = mpsc_pkg::ACC_W;
  localparam int unsigned VW = mpsc_pkg::VAL_W;

  logic [4:0] sig_len_q;
  logic [5:0] atom_cnt_q, sparsity_q;

  logic signed [15:0] dict_mem [MAX_SIGNAL_LEN*MAX_ATOMS];
  logic signed [VW-1:0] sig_mem [MAX_SIGNAL_LEN];
  logic signed [VW-1:0] res_mem [MAX_SIGNAL_LEN];
  logic [MAX_ATOMS-1:0] chosen_q;  // coefficient nonzero

  mpsc_pkg::state_e state_q, state_d;

  logic [RW:0] n_eff, k_q;
  logic [AW:0] m_eff, i_q;
  logic [AW:0] rounds, j_q;
  logic [AW-1:0] best_q;
  logic found_q;
  logic signed [ACC-1:0] best_sum_q, acc_q;
  logic [ACC-1:0] best_mag_q;
  logic signed [VW-1:0] proj_q;
  logic signed [15:0] dict_rd_q;
  logic signed [VW-1:0] res_rd_q, sig_rd_q;
  logic mac_v_q;
  logic [RW-1:0] mac_k_q;
  logic signed [mpsc_pkg::PROD_W-1:0] prod_q;
  logic prod_v_q;
  logic [RW-1:0] prod_k_q;

  logic out_valid_q, kind_q, last_q;
  logic [4:0] index_q;
  logic signed [VW-1:0] value_q;

  // effective sizes
  always_comb begin
    logic [5:0] ns;
    logic [6:0] ms;
    ns = {1'b0, sig_len_q};
    if (ns < 6'd1) ns = 6'd1;
    if (32'(ns) > MAX_SIGNAL_LEN) ns = 6'(MAX_SIGNAL_LEN);
    n_eff = (RW+1)'(ns);
    ms = {1'b0, atom_cnt_q};
    if (ms < 7'd1) ms = 7'd1;
    if (32'(ms) > MAX_ATOMS) ms = 7'(MAX_ATOMS);
    m_eff = (AW+1)'(ms);
    rounds = (32'(sparsity_q) < 32'(m_eff)) ? (AW+1)'(sparsity_q) : m_eff;
  end

  wire in_fire = in_valid_i && in_ready_o;
  wire out_fire = out_valid_o && out_ready_i;
  assign in_ready_o = (state_q == mpsc_pkg::ST_IDLE);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_len_q <= 5'd16;
      atom_cnt_q <= 6'd32;
      sparsity_q <= 6'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpsc_pkg::CFG_SIG_LEN:  sig_len_q <= cfg_data_i[4:0];
        mpsc_pkg::CFG_ATOM_CNT: atom_cnt_q <= cfg_data_i;
        mpsc_pkg::CFG_SPARSITY: sparsity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memory addresses
  logic [RW-1:0] k_idx;
  logic [AW-1:0] i_idx;
  assign k_idx = k_q[RW-1:0];
  assign i_idx = i_q[AW-1:0];
  wire [AW-1:0] dict_col = (state_q == mpsc_pkg::ST_UPD) ? best_q : i_idx;
  wire [DW-1:0] dict_addr = {k_idx, dict_col};

  wire load_dict = in_fire && opcode_i == mpsc_pkg::OP_LOAD_DICT
                   && 32'(row_index_i) < MAX_SIGNAL_LEN && 32'(atom_index_i) < MAX_ATOMS;
  wire load_sig = in_fire && opcode_i == mpsc_pkg::OP_LOAD_SIG
                  && 32'(row_index_i) < MAX_SIGNAL_LEN;

  always_ff @(posedge clk_i) begin
    if (load_dict) dict_mem[{RW'(row_index_i), AW'(atom_index_i)}] <= dict_word_i;
    dict_rd_q <= dict_mem[dict_addr];
  end

  always_ff @(posedge clk_i) begin
    if (load_sig) sig_mem[RW'(row_index_i)] <= sample_i;
    sig_rd_q <= sig_mem[k_idx];
  end

  // residual write port: copy or update
  logic res_we;
  logic [RW-1:0] res_wa;
  logic signed [VW-1:0] res_wd;
  always_ff @(posedge clk_i) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_q <= res_mem[k_idx];
  end

  // shared multiplier: residual*dict or proj*dict
  wire signed [VW-1:0] mul_a = (state_q == mpsc_pkg::ST_UPD || state_q == mpsc_pkg::ST_UPD_WAIT)
                               ? proj_q : res_rd_q;
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * dict_rd_q;
    prod_k_q <= mac_k_q;
  end

  wire signed [ACC-1:0] prod_ext = ACC'(prod_q);
  wire signed [ACC-1:0] upd_d = mpsc_pkg::round15(prod_ext);
  wire [ACC-1:0] acc_mag = acc_q[ACC-1] ? ACC'(-acc_q) : ACC'(acc_q);

  // residual sample registered once more so it lines up with its product
  logic signed [VW-1:0] res_d1_q;
  always_ff @(posedge clk_i) begin
    res_d1_q <= res_rd_q;
  end
  wire signed [ACC-1:0] upd_r2 = ACC'(res_d1_q) - upd_d;

  always_comb begin
    res_we = 1'b0;
    res_wa = prod_k_q;
    res_wd = mpsc_pkg::sat24(upd_r2);
    if (state_q == mpsc_pkg::ST_INIT && mac_v_q) begin
      res_we = 1'b1;
      res_wa = mac_k_q;
      res_wd = sig_rd_q;
    end else if ((state_q == mpsc_pkg::ST_UPD || state_q == mpsc_pkg::ST_UPD_WAIT) && prod_v_q) begin
      res_we = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mpsc_pkg::ST_IDLE:
        if (in_fire && opcode_i == mpsc_pkg::OP_RUN) state_d = mpsc_pkg::ST_INIT;
      mpsc_pkg::ST_INIT:
        if (k_q == n_eff && mac_v_q) state_d = (rounds == '0) ? mpsc_pkg::ST_EMIT_RES
                                                              : mpsc_pkg::ST_DOT;
      mpsc_pkg::ST_DOT:
        if (k_q == n_eff || chosen_q[i_idx]) state_d = mpsc_pkg::ST_DOT_WAIT;
      mpsc_pkg::ST_DOT_WAIT:
        if (!mac_v_q && !prod_v_q) state_d = mpsc_pkg::ST_PICK;
      mpsc_pkg::ST_PICK:
        state_d = (i_q + 1'b1 == m_eff) ? mpsc_pkg::ST_PROJ : mpsc_pkg::ST_DOT;
      mpsc_pkg::ST_PROJ: state_d = mpsc_pkg::ST_UPD;
      mpsc_pkg::ST_UPD:
        if (k_q == n_eff) state_d = mpsc_pkg::ST_UPD_WAIT;
      mpsc_pkg::ST_UPD_WAIT:
        if (!mac_v_q && !prod_v_q) state_d = mpsc_pkg::ST_EMIT_COEF;
      mpsc_pkg::ST_EMIT_COEF:
        if (!out_valid_q || out_fire)
          state_d = (j_q + 1'b1 == rounds) ? mpsc_pkg::ST_EMIT_RES : mpsc_pkg::ST_DOT;
      mpsc_pkg::ST_EMIT_RES: state_d = mpsc_pkg::ST_RES_WAIT;
      mpsc_pkg::ST_RES_WAIT:
        if (!out_valid_q || out_fire)
          state_d = (k_q + 1'b1 == n_eff) ? mpsc_pkg::ST_IDLE : mpsc_pkg::ST_EMIT_RES;
      default: state_d = mpsc_pkg::ST_IDLE;
    endcase
  end

  // datapath sequencing
  wire dot_issue = state_q == mpsc_pkg::ST_DOT && k_q != n_eff && !chosen_q[i_idx];
  wire upd_issue = state_q == mpsc_pkg::ST_UPD && k_q != n_eff;
  wire init_issue = state_q == mpsc_pkg::ST_INIT && k_q != n_eff;
  wire emit_beat = (state_q == mpsc_pkg::ST_EMIT_COEF || state_q == mpsc_pkg::ST_RES_WAIT)
                   && (!out_valid_q || out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpsc_pkg::ST_IDLE;
      k_q <= '0;
      i_q <= '0;
      j_q <= '0;
      mac_v_q <= 1'b0;
      prod_v_q <= 1'b0;
      found_q <= 1'b0;
      chosen_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mac_v_q <= dot_issue || upd_issue || init_issue;
      mac_k_q <= k_idx;
      prod_v_q <= mac_v_q && state_q != mpsc_pkg::ST_INIT;
      if (emit_beat) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
      unique case (state_q)
        mpsc_pkg::ST_IDLE: begin
          k_q <= '0;
          chosen_q <= '0;
        end
        mpsc_pkg::ST_INIT: begin
          if (k_q != n_eff) k_q <= k_q + 1'b1;
          if (state_d == mpsc_pkg::ST_DOT) begin
            k_q <= '0; i_q <= '0; j_q <= '0; found_q <= 1'b0; acc_q <= '0;
          end else if (state_d == mpsc_pkg::ST_EMIT_RES) k_q <= '0;
        end
        mpsc_pkg::ST_DOT: begin
          if (dot_issue) k_q <= k_q + 1'b1;
        end
        mpsc_pkg::ST_DOT_WAIT:
          if (prod_v_q) acc_q <= acc_q + prod_ext;
        mpsc_pkg::ST_PICK: begin
          if (!chosen_q[i_idx] && (!found_q || acc_mag > best_mag_q)) begin
            found_q <= 1'b1;
            best_mag_q <= acc_mag;
            best_sum_q <= acc_q;
            best_q <= i_idx;
          end
          acc_q <= '0;
          k_q <= '0;
          i_q <= i_q + 1'b1;
        end
        mpsc_pkg::ST_PROJ: begin
          if (!found_q) best_q <= '0;
          proj_q <= found_q ? mpsc_pkg::sat24(mpsc_pkg::round15(best_sum_q)) : '0;
          k_q <= '0;
        end
        mpsc_pkg::ST_UPD:
          if (upd_issue) k_q <= k_q + 1'b1;
        mpsc_pkg::ST_UPD_WAIT: ;
        mpsc_pkg::ST_EMIT_COEF:
          if (emit_beat) begin
            kind_q <= 1'b0;
            index_q <= 5'(best_q);
            value_q <= proj_q;
            last_q <= 1'b0;
            if (proj_q != '0) chosen_q[best_q] <= 1'b1;
            j_q <= j_q + 1'b1;
            i_q <= '0; k_q <= '0; found_q <= 1'b0; acc_q <= '0;
          end
        mpsc_pkg::ST_EMIT_RES: ;
        mpsc_pkg::ST_RES_WAIT:
          if (emit_beat) begin
            kind_q <= 1'b1;
            index_q <= 5'(k_q);
            value_q <= res_rd_q;
            last_q <= (k_q + 1'b1 == n_eff);
            k_q <= k_q + 1'b1;
          end
        default: ;
      endcase
      // accumulate in the dot state as products arrive
      if (state_q == mpsc_pkg::ST_DOT && prod_v_q) acc_q <= acc_q + prod_ext;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign index_o = index_q;
  assign value_o = value_q;
  assign last_o = last_q;

  `CHK_IMPL(a_busy_no_ready, clk_i, rst_ni, state_q != mpsc_pkg::ST_IDLE, !in_ready_o)
  `CHK_IMPL(a_hold_out, clk_i, rst_ni, out_valid_o && !out_ready_i, ##1 out_valid_o)
  `CHK_IMPL(a_last_is_res, clk_i, rst_ni, out_valid_o && last_o, kind_o)

endmodule
